@@ rtl/key_repeat_and_dpad_resolver_assert.svh @@
// Assertion helpers for the key repeat block.
// Both expect clk and rst_n in scope; checks are off while reset is low.
`ifndef KEY_REPEAT_AND_DPAD_RESOLVER_ASSERT_SVH
`define KEY_REPEAT_AND_DPAD_RESOLVER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KRD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/krd_pkg.sv @@
package krd_pkg;

  localparam int NUM_KEYS_DEF    = 16;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int KEY_W     = 16;
  localparam int MASK_W    = 16;
  localparam int REG_W     = 16;
  localparam int DIR_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W     = 4 * MASK_W + 2 * DIR_W;
  localparam int DIR_LANES = 12;

  // count bits resolved per cycle in each lane while it steps
  localparam int BITS_PER_STEP = 4;

  localparam logic [CFG_IDX_W-1:0] REG_START_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 2'd1;

  localparam logic [REG_W-1:0] START_DELAY_RST = 16'd20;
  localparam logic [REG_W-1:0] PERIOD_RST      = 16'd10;

  // keypad-layout direction codes
  localparam logic [DIR_W-1:0] DIR_NONE       = 4'd0;
  localparam logic [DIR_W-1:0] DIR_DOWN_LEFT  = 4'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN       = 4'd2;
  localparam logic [DIR_W-1:0] DIR_DOWN_RIGHT = 4'd3;
  localparam logic [DIR_W-1:0] DIR_LEFT       = 4'd4;
  localparam logic [DIR_W-1:0] DIR_RIGHT      = 4'd6;
  localparam logic [DIR_W-1:0] DIR_UP_LEFT    = 4'd7;
  localparam logic [DIR_W-1:0] DIR_UP         = 4'd8;
  localparam logic [DIR_W-1:0] DIR_UP_RIGHT   = 4'd9;

  // fixed directional lanes
  localparam int LANE_KP1   = 0;
  localparam int LANE_KP2   = 1;
  localparam int LANE_KP3   = 2;
  localparam int LANE_KP4   = 3;
  localparam int LANE_KP6   = 4;
  localparam int LANE_KP7   = 5;
  localparam int LANE_KP8   = 6;
  localparam int LANE_KP9   = 7;
  localparam int LANE_DOWN  = 8;
  localparam int LANE_LEFT  = 9;
  localparam int LANE_RIGHT = 10;
  localparam int LANE_UP    = 11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic pressed;
    logic trig;
    logic rep;
    logic rel;
  } lane_flags_t;

  typedef struct packed {
    logic [DIR_W-1:0]  dir_eight;
    logic [DIR_W-1:0]  dir_four;
    logic [MASK_W-1:0] released;
    logic [MASK_W-1:0] repeated;
    logic [MASK_W-1:0] triggered;
    logic [MASK_W-1:0] pressed;
  } result_t;

endpackage

@@ rtl/krd_lane.sv @@
module krd_lane import krd_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  logic                   clr,
  input  logic                   key_bit,
  input  logic                   step_en,
  input  logic [REG_W-1:0]       start_delay,
  input  logic [REG_W-1:0]       period,
  output logic [COUNT_WIDTH-1:0] count,
  output lane_flags_t            flags
);

  localparam int DIV_CYCLES = (COUNT_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int SH_W       = DIV_CYCLES * BITS_PER_STEP;
  localparam int CMP_W      = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                   rel_r, rel_nxt;
  logic [SH_W-1:0]        sh_r, sh_nxt;
  logic [REG_W-1:0]       rem_r, rem_nxt;
  logic [REG_W:0]         part;

  always_comb begin
    cnt_nxt = cnt_r;
    rel_nxt = rel_r;
    sh_nxt  = sh_r;
    rem_nxt = rem_r;
    part    = '0;
    if (load) begin
      if (clr) begin
        cnt_nxt = '0;
        rel_nxt = 1'b0;
      end else if (key_bit) begin
        cnt_nxt = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + CNT_ONE;
        rel_nxt = 1'b0;
      end else begin
        cnt_nxt = '0;
        rel_nxt = (cnt_r != '0);
      end
      sh_nxt  = SH_W'(cnt_nxt);
      rem_nxt = '0;
    end else if (step_en) begin
      // restoring remainder, BITS_PER_STEP count bits per cycle, MSB first
      for (int b = 0; b < BITS_PER_STEP; b++) begin
        part   = {rem_nxt, sh_nxt[SH_W-1]};
        sh_nxt = sh_nxt << 1;
        if (part >= {1'b0, period}) begin
          part = part - {1'b0, period};
        end
        rem_nxt = part[REG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rel_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rel_r <= rel_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign count = cnt_r;

  always_comb begin
    flags.pressed = (cnt_r != '0);
    flags.trig    = (cnt_r == CNT_ONE);
    flags.rep     = flags.pressed &&
                    (flags.trig ||
                     ((CMP_W'(cnt_r) >= CMP_W'(start_delay)) &&
                      (period != '0) && (rem_r == '0)));
    flags.rel     = rel_r;
  end

endmodule

@@ rtl/krd_merge.sv @@
module krd_merge import krd_pkg::*; #(
  parameter int NUM_KEYS    = NUM_KEYS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic [COUNT_WIDTH-1:0] dir_counts [DIR_LANES],
  input  lane_flags_t            flags [NUM_KEYS],
  output result_t                res
);

  localparam int O_DOWN  = 0;
  localparam int O_LEFT  = 1;
  localparam int O_RIGHT = 2;
  localparam int O_UP    = 3;

  // stage 1: longest hold per orthogonal, own-lane hold per diagonal
  logic [COUNT_WIDTH-1:0] orth_hold_r [4];
  logic d1_r, d3_r, d7_r, d9_r;

  // stage 2: cancel, diagonal held, pair winners (down/left, right/up)
  logic                   cancel_r;
  logic                   dg1_r, dg3_r, dg7_r, dg9_r;
  logic                   wa_ok_r, wb_ok_r;
  logic [DIR_W-1:0]       wa_dir_r, wb_dir_r;
  logic [COUNT_WIDTH-1:0] wa_hold_r, wb_hold_r;

  logic [3:0]       held;
  logic [DIR_W-1:0] sel_dir, dir4, dir8;

  function automatic logic [COUNT_WIDTH-1:0] hmax(input logic [COUNT_WIDTH-1:0] a,
                                                  input logic [COUNT_WIDTH-1:0] b);
    hmax = (a > b) ? a : b;
  endfunction

  always_ff @(posedge clk) begin
    orth_hold_r[O_DOWN]  <= hmax(dir_counts[LANE_KP2], dir_counts[LANE_DOWN]);
    orth_hold_r[O_LEFT]  <= hmax(dir_counts[LANE_KP4], dir_counts[LANE_LEFT]);
    orth_hold_r[O_RIGHT] <= hmax(dir_counts[LANE_KP6], dir_counts[LANE_RIGHT]);
    orth_hold_r[O_UP]    <= hmax(dir_counts[LANE_KP8], dir_counts[LANE_UP]);
    d1_r <= (dir_counts[LANE_KP1] != '0);
    d3_r <= (dir_counts[LANE_KP3] != '0);
    d7_r <= (dir_counts[LANE_KP7] != '0);
    d9_r <= (dir_counts[LANE_KP9] != '0);
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      held[k] = (orth_hold_r[k] != '0);
    end
  end

  always_ff @(posedge clk) begin
    cancel_r <= (held[O_DOWN] && held[O_UP]) || (held[O_LEFT] && held[O_RIGHT]);
    dg1_r    <= d1_r || (held[O_DOWN] && held[O_LEFT]);
    dg3_r    <= d3_r || (held[O_DOWN] && held[O_RIGHT]);
    dg7_r    <= d7_r || (held[O_UP] && held[O_LEFT]);
    dg9_r    <= d9_r || (held[O_UP] && held[O_RIGHT]);
    wa_ok_r  <= held[O_DOWN] || held[O_LEFT];
    wb_ok_r  <= held[O_RIGHT] || held[O_UP];
    // shortest hold wins, lower code on a tie
    if (held[O_DOWN] && (!held[O_LEFT] || orth_hold_r[O_DOWN] <= orth_hold_r[O_LEFT])) begin
      wa_dir_r  <= DIR_DOWN;
      wa_hold_r <= orth_hold_r[O_DOWN];
    end else begin
      wa_dir_r  <= DIR_LEFT;
      wa_hold_r <= orth_hold_r[O_LEFT];
    end
    if (held[O_RIGHT] && (!held[O_UP] || orth_hold_r[O_RIGHT] <= orth_hold_r[O_UP])) begin
      wb_dir_r  <= DIR_RIGHT;
      wb_hold_r <= orth_hold_r[O_RIGHT];
    end else begin
      wb_dir_r  <= DIR_UP;
      wb_hold_r <= orth_hold_r[O_UP];
    end
  end

  always_comb begin
    if (wa_ok_r && (!wb_ok_r || wa_hold_r <= wb_hold_r)) begin
      sel_dir = wa_dir_r;
    end else if (wb_ok_r) begin
      sel_dir = wb_dir_r;
    end else begin
      sel_dir = DIR_NONE;
    end
    dir4 = cancel_r ? DIR_NONE : sel_dir;
    dir8 = dir4;
    if (!cancel_r) begin
      if (dg9_r) begin
        dir8 = DIR_UP_RIGHT;
      end else if (dg7_r) begin
        dir8 = DIR_UP_LEFT;
      end else if (dg3_r) begin
        dir8 = DIR_DOWN_RIGHT;
      end else if (dg1_r) begin
        dir8 = DIR_DOWN_LEFT;
      end
    end
  end

  for (genvar i = 0; i < MASK_W; i++) begin : g_mask
    if (i < NUM_KEYS) begin : g_lane
      assign res.pressed[i]   = flags[i].pressed;
      assign res.triggered[i] = flags[i].trig;
      assign res.repeated[i]  = flags[i].rep;
      assign res.released[i]  = flags[i].rel;
    end else begin : g_none
      assign res.pressed[i]   = 1'b0;
      assign res.triggered[i] = 1'b0;
      assign res.repeated[i]  = 1'b0;
      assign res.released[i]  = 1'b0;
    end
  end

  assign res.dir_four  = dir4;
  assign res.dir_eight = dir8;

endmodule

@@ rtl/key_repeat_and_dpad_resolver.sv @@
// Key auto-repeat and d-pad resolver.
// in_*  : one transaction per tick. in_tuser[0] = 1 clears every hold counter;
//         in_tdata holds one held bit per key lane (lanes 0-11 directional).
// out_* : one result transaction per input transaction. Each lane keeps its
//         own counter and remainder unit; a merging stage builds the masks
//         and resolves the 4-way and 8-way directions.
// cfg_* : register writes (index 0 start delay, 1 repeat period), always
//         ready; write only while no tick is in flight.
// Flow: an accepted tick loads the lane counters, each lane's remainder unit
// then resolves 4 count bits per cycle against the repeat period in ST_DIV,
// and the result is registered in ST_DONE. A new tick is taken only in
// ST_IDLE, once the previous one has been loaded into the output register.
// A finished result sits in the output register; the next tick is accepted
// and worked on while it waits, and only its load stalls behind a receiver
// that holds out_tready low.
// Reset: counters zero, registers 20 and 10, no result pending.
module key_repeat_and_dpad_resolver import krd_pkg::*; #(
  parameter int NUM_KEYS    = NUM_KEYS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [KEY_W-1:0]     in_tdata,   // key_states
  input  logic [0:0]           in_tuser,   // req_type
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // pressed_mask, triggered_mask, repeat_mask, released_mask, dir_four, dir_eight
  output logic [OUT_W-1:0]     out_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

`include "key_repeat_and_dpad_resolver_assert.svh"

  localparam int DIV_CYCLES = (COUNT_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int STEP_W     = (DIV_CYCLES > 2) ? $clog2(DIV_CYCLES) : 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_CYCLES - 1);
  localparam logic [STEP_W-1:0] STEP_ONE  = STEP_W'(1);

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [REG_W-1:0]    start_delay_r, start_delay_nxt;
  logic [REG_W-1:0]    period_r, period_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_data_r;
  logic                in_acc, out_free, out_load, step_en, clr_in;

  logic [COUNT_WIDTH-1:0] counts [NUM_KEYS];
  logic [COUNT_WIDTH-1:0] dir_counts [DIR_LANES];
  lane_flags_t            flags [NUM_KEYS];
  result_t                res;
  logic                   cnt_any;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign clr_in   = in_tuser[0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_DIV;
      ST_DIV:  if (step_r == LAST_STEP) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == ST_IDLE);
    step_en   = (state_r == ST_DIV);
    out_load  = (state_r == ST_DONE) && out_free;
    step_nxt  = step_en ? step_r + STEP_ONE : '0;
  end

  always_comb begin
    start_delay_nxt = start_delay_r;
    period_nxt      = period_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_DELAY: start_delay_nxt = cfg_data;
        REG_PERIOD:      period_nxt      = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      step_r        <= '0;
      start_delay_r <= START_DELAY_RST;
      period_r      <= PERIOD_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      step_r        <= step_nxt;
      start_delay_r <= start_delay_nxt;
      period_r      <= period_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    if (out_load) begin
      out_data_r <= {res.dir_eight, res.dir_four, res.released,
                     res.repeated, res.triggered, res.pressed};
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_lane
    logic key_bit;
    if (i < KEY_W) begin : g_in
      assign key_bit = in_tdata[i];
    end else begin : g_zero
      assign key_bit = 1'b0;
    end
    krd_lane #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .load       (in_acc),
      .clr        (clr_in),
      .key_bit    (key_bit),
      .step_en    (step_en),
      .start_delay(start_delay_r),
      .period     (period_r),
      .count      (counts[i]),
      .flags      (flags[i])
    );
  end

  for (genvar j = 0; j < DIR_LANES; j++) begin : g_dir
    assign dir_counts[j] = counts[j];
  end

  krd_merge #(
    .NUM_KEYS   (NUM_KEYS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_merge (
    .clk       (clk),
    .dir_counts(dir_counts),
    .flags     (flags),
    .res       (res)
  );

  always_comb begin
    cnt_any = 1'b0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      cnt_any = cnt_any | (counts[k] != '0);
    end
  end

  `KRD_ASSERT_NEXT(a_accept_starts_div, in_tvalid && in_tready, state_r == ST_DIV,
                   "accepted tick did not start the remainder pass")
  `KRD_ASSERT_NOW(a_step_in_range, state_r == ST_DIV, step_r <= LAST_STEP,
                  "step counter ran past the last remainder step")
  `KRD_ASSERT_NOW(a_result_from_done, $rose(out_valid_r), $past(state_r) == ST_DONE,
                  "result appeared without finishing a tick")
  `KRD_ASSERT_NEXT(a_clear_zeroes, in_tvalid && in_tready && in_tuser[0], !cnt_any,
                   "clear left a hold counter nonzero")

endmodule
